>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the I2C master bit engine checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/i2cm_pkg.sv
// ---------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, engine state and channel word types.
// ---------------------------------------------------------------------------
package i2cm_pkg;

   // func codes on the request channel
   localparam logic [2:0] FUNC_TICK  = 3'd0;
   localparam logic [2:0] FUNC_START = 3'd1;
   localparam logic [2:0] FUNC_STOP  = 3'd2;
   localparam logic [2:0] FUNC_WRITE = 3'd3;
   localparam logic [2:0] FUNC_READ  = 3'd4;
   localparam logic [2:0] FUNC_SACK  = 3'd5;
   localparam logic [2:0] FUNC_WACK  = 3'd6;

   localparam logic [7:0] POLL_LIMIT_RESET = 8'd200;

   typedef enum logic [6:0] {
      CMD_IDLE  = 7'b0000001,
      CMD_START = 7'b0000010,
      CMD_STOP  = 7'b0000100,
      CMD_WRITE = 7'b0001000,
      CMD_READ  = 7'b0010000,
      CMD_SACK  = 7'b0100000,
      CMD_WACK  = 7'b1000000
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [4:0] phase;
      logic [7:0] shift;
      logic [7:0] polls;
      logic       scl;
      logic       sda;
      logic [7:0] rx_byte;
      logic       stop_tmo;
   } eng_state_type;

   typedef struct packed {
      logic [2:0] func;
      logic [7:0] data_byte;
      logic       ack_level;
      logic       sda_in;
   } req_word_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_data;
      logic       ack_seen;
      logic       timed_out;
      logic       rejected;
   } rsp_word_type;

   function automatic cmd_type func_to_cmd(input logic [2:0] f);
      cmd_type c;
      case (f)
         FUNC_START: c = CMD_START;
         FUNC_STOP:  c = CMD_STOP;
         FUNC_WRITE: c = CMD_WRITE;
         FUNC_READ:  c = CMD_READ;
         FUNC_SACK:  c = CMD_SACK;
         FUNC_WACK:  c = CMD_WACK;
         default:    c = CMD_IDLE;
      endcase
      return c;
   endfunction

endpackage

>>> hdl/i2cm_if.sv
// ---------------------------------------------------------------------------
// I2C master bit engine channel interfaces
// Request, response and control/status write channels.
// ---------------------------------------------------------------------------
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [7:0] data_byte;
   logic       ack_level;
   logic       sda_in;
   modport source (output valid, func, data_byte, ack_level, sda_in, input ready);
   modport sink   (input valid, func, data_byte, ack_level, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_data;
   logic       ack_seen;
   logic       timed_out;
   logic       rejected;
   modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_data,
                   ack_seen, timed_out, rejected, input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_data,
                   ack_seen, timed_out, rejected, output ready);
endinterface

interface i2cm_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] wdata;
   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

>>> hdl/i2cm_step.sv
// ---------------------------------------------------------------------------
// I2C master bit engine step logic
// Advance the command sequencer by one tick and form the response word.
// ---------------------------------------------------------------------------
module i2cm_step
   import i2cm_pkg::*;
(
   input  eng_state_type cur_state,
   input  req_word_type  req_word,
   input  logic [7:0]    poll_limit,
   output eng_state_type nxt_state,
   output rsp_word_type  rsp_word
);

   eng_state_type s;
   logic          is_cmd;
   logic          finish;
   logic          rej;
   logic          ack;
   logic          tmo;
   logic [4:0]    p;
   logic [4:0]    nxt_p;
   logic [8:0]    cnt;

   always_comb begin
      s      = cur_state;
      finish = 1'b0;
      rej    = 1'b0;
      ack    = 1'b0;
      tmo    = 1'b0;
      cnt    = {1'b0, cur_state.polls} + 9'd1;
      is_cmd = (req_word.func >= FUNC_START) && (req_word.func <= FUNC_WACK);

      // take a new command only when idle
      if (s.cmd != CMD_IDLE) begin
         rej = is_cmd;
      end else if (is_cmd) begin
         s.cmd      = func_to_cmd(req_word.func);
         s.phase    = 5'd0;
         s.polls    = 8'd0;
         s.stop_tmo = 1'b0;
         if (req_word.func == FUNC_WRITE) begin
            s.shift = req_word.data_byte;
         end else if (req_word.func == FUNC_SACK) begin
            s.shift = {7'd0, req_word.ack_level};
         end else begin
            s.shift = 8'd0;
         end
      end

      p     = s.phase;
      nxt_p = p + 5'd1;

      case (s.cmd)
         CMD_START: begin
            if (p == 5'd0) begin
               s.scl = 1'b1; s.sda = 1'b1;
            end else if (p == 5'd1) begin
               s.scl = 1'b1; s.sda = 1'b0;
            end else begin
               s.scl = 1'b0; s.sda = 1'b0; finish = 1'b1;
            end
         end
         CMD_STOP: begin
            if (p == 5'd0) begin
               s.scl = 1'b0; s.sda = 1'b0;
            end else if (p == 5'd1) begin
               s.scl = 1'b1; s.sda = 1'b0;
            end else begin
               s.scl = 1'b1; s.sda = 1'b1; finish = 1'b1;
               tmo = s.stop_tmo;
            end
         end
         CMD_WRITE: begin
            if (p < 5'd16) begin
               s.scl = p[0];
               s.sda = s.shift[7];
               if (p[0]) begin
                  s.shift = {s.shift[6:0], 1'b0};
               end
            end else begin
               s.scl = 1'b0; finish = 1'b1;
            end
         end
         CMD_READ: begin
            if (!p[0]) begin
               s.scl = 1'b1; s.sda = 1'b1;
               s.shift = {s.shift[6:0], req_word.sda_in};
            end else begin
               s.scl = 1'b0; s.sda = 1'b1;
               if (p >= 5'd15) begin
                  s.rx_byte = s.shift;
                  finish = 1'b1;
               end
            end
         end
         CMD_SACK: begin
            if (p == 5'd0) begin
               s.scl = 1'b0; s.sda = s.shift[0];
            end else if (p == 5'd1) begin
               s.scl = 1'b1; s.sda = s.shift[0];
            end else begin
               s.scl = 1'b0; s.sda = 1'b1; finish = 1'b1;
            end
         end
         CMD_WACK: begin
            if (p == 5'd0) begin
               s.scl = 1'b0; s.sda = 1'b1;
            end else if (p == 5'd1) begin
               s.scl = 1'b1; s.sda = 1'b1;
            end else if (p == 5'd2) begin
               s.scl = 1'b1; s.sda = 1'b1;
               if (!req_word.sda_in) begin
                  nxt_p = 5'd3;
               end else if (cnt > {1'b0, poll_limit}) begin
                  // poll limit exceeded: fall into the stop sequence
                  s.cmd      = CMD_STOP;
                  s.stop_tmo = 1'b1;
                  nxt_p      = 5'd0;
               end else begin
                  s.polls = cnt[7:0];
                  nxt_p   = 5'd2;
               end
            end else begin
               s.scl = 1'b0; s.sda = 1'b1; ack = 1'b1; finish = 1'b1;
            end
         end
         default: begin
            s.cmd = CMD_IDLE;
         end
      endcase

      if (finish) begin
         s.cmd      = CMD_IDLE;
         s.phase    = 5'd0;
         s.stop_tmo = 1'b0;
      end else if (s.cmd != CMD_IDLE) begin
         s.phase = nxt_p;
      end else begin
         s.phase = 5'd0;
      end

      nxt_state          = s;
      rsp_word.scl_out   = s.scl;
      rsp_word.sda_out   = s.sda;
      rsp_word.busy_res  = (s.cmd != CMD_IDLE);
      rsp_word.done_res  = finish;
      rsp_word.rx_data   = s.rx_byte;
      rsp_word.ack_seen  = ack;
      rsp_word.timed_out = tmo;
      rsp_word.rejected  = rej;
   end

endmodule

>>> hdl/i2c_master_bit_engine.sv
// ---------------------------------------------------------------------------
// I2C master bit engine
// Sequence open-drain SCL/SDA levels, one request word per bit-delay tick.
// ---------------------------------------------------------------------------
//   channel   dir   carries
//   req_ch    in    func, data_byte, ack_level, sda_in (one tick per word)
//   rsp_ch    out   scl_out, sda_out, busy_res, done_res, rx_data, ack_seen,
//                   timed_out, rejected (one word per request word)
//   csr_ch    in    wdata = ack_poll_limit, always ready
//
// A request word lands in the input register when accepted; the step logic
// then writes its response word into the response register once that
// register is free. One word per cycle is sustained while the response
// side is ready; the engine state advances when a word moves into the
// response register. A stalled response backs up into the input register
// and then drops req ready. Synchronous reset clears the engine to idle with
// both lines released and the poll limit at 200.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine
   import i2cm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   i2cm_req_if.sink     req_ch,
   i2cm_rsp_if.source   rsp_ch,
   i2cm_csr_if.sink     csr_ch
);

   // input register
   logic          in_valid_ff;
   logic          in_valid_in;
   req_word_type  in_word_ff;

   // engine state and poll limit
   eng_state_type state_ff;
   eng_state_type state_in;
   logic [7:0]    limit_ff;

   // response register
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_word_type  rsp_word_ff;
   rsp_word_type  rsp_word_in;

   logic          advance;
   logic          req_take;

   // move a word to the response side when the response register is free
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   i2cm_step u_step (
      .cur_state  (state_ff),
      .req_word   (in_word_ff),
      .poll_limit (limit_ff),
      .nxt_state  (state_in),
      .rsp_word   (rsp_word_in)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= POLL_LIMIT_RESET;
         state_ff     <= '{cmd: CMD_IDLE, phase: 5'd0, shift: 8'd0, polls: 8'd0,
                           scl: 1'b1, sda: 1'b1, rx_byte: 8'd0, stop_tmo: 1'b0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            limit_ff <= csr_ch.wdata;
         end
         // advance the sequencer one tick per word
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff.func      <= req_ch.func;
         in_word_ff.data_byte <= req_ch.data_byte;
         in_word_ff.ack_level <= req_ch.ack_level;
         in_word_ff.sda_in    <= req_ch.sda_in;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.scl_out   = rsp_word_ff.scl_out;
   assign rsp_ch.sda_out   = rsp_word_ff.sda_out;
   assign rsp_ch.busy_res  = rsp_word_ff.busy_res;
   assign rsp_ch.done_res  = rsp_word_ff.done_res;
   assign rsp_ch.rx_data   = rsp_word_ff.rx_data;
   assign rsp_ch.ack_seen  = rsp_word_ff.ack_seen;
   assign rsp_ch.timed_out = rsp_word_ff.timed_out;
   assign rsp_ch.rejected  = rsp_word_ff.rejected;

endmodule

>>> hdl/i2cm_checker.sv
// ---------------------------------------------------------------------------
// I2C master bit engine checker
// Port-level checks on the response channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       scl_out,
   input logic       sda_out,
   input logic       busy_res,
   input logic       done_res,
   input logic [7:0] rx_data,
   input logic       ack_seen,
   input logic       timed_out
);

   // hold a stalled response word
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(scl_out) && $stable(sda_out) && $stable(rx_data) && $stable(done_res), "stalled response word changed")

   // a finished command leaves the engine idle
   `ASSERT_SAME(a_done_idle, clock, reset, rsp_valid && done_res, !busy_res, "done with busy set")

   // a timeout ends a stop: both lines released
   `ASSERT_SAME(a_tmo_stop, clock, reset, rsp_valid && timed_out, done_res && scl_out && sda_out && !ack_seen, "timeout without stop finish")

   // an ack is seen on the closing low-SCL tick
   `ASSERT_SAME(a_ack_tail, clock, reset, rsp_valid && ack_seen, done_res && !scl_out && sda_out, "ack flag outside wait-ack tail")

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .scl_out   (rsp_ch.scl_out),
   .sda_out   (rsp_ch.sda_out),
   .busy_res  (rsp_ch.busy_res),
   .done_res  (rsp_ch.done_res),
   .rx_data   (rsp_ch.rx_data),
   .ack_seen  (rsp_ch.ack_seen),
   .timed_out (rsp_ch.timed_out)
);

>>> dv/i2cm_sb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C master bit engine scoreboard
// Tracks the engine state tick by tick and checks every response word.
// ---------------------------------------------------------------------------
package i2cm_sb_pkg;
   import i2cm_pkg::*;

   class line_scoreboard;
      logic [7:0]   poll_limit;
      cmd_type      cmd;
      logic [4:0]   phase;
      logic [7:0]   shift;
      logic [7:0]   polls;
      logic         scl;
      logic         sda;
      logic [7:0]   rx_byte;
      logic         stop_tmo;
      rsp_word_type expected_rsp_q[$];
      int           errors;
      int           checked;

      function new();
         poll_limit = POLL_LIMIT_RESET;
         cmd        = CMD_IDLE;
         phase      = '0;
         shift      = '0;
         polls      = '0;
         scl        = 1'b1;
         sda        = 1'b1;
         rx_byte    = '0;
         stop_tmo   = 1'b0;
         errors     = 0;
         checked    = 0;
      endfunction

      function bit engine_busy();
         return cmd != CMD_IDLE;
      endfunction

      function int pending();
         return expected_rsp_q.size();
      endfunction

      function cmd_type cmd_for(logic [2:0] f);
         case (f)
            FUNC_START: return CMD_START;
            FUNC_STOP:  return CMD_STOP;
            FUNC_WRITE: return CMD_WRITE;
            FUNC_READ:  return CMD_READ;
            FUNC_SACK:  return CMD_SACK;
            FUNC_WACK:  return CMD_WACK;
            default:    return CMD_IDLE;
         endcase
      endfunction

      // Advance the engine by one tick and queue the word it must produce.
      function void note_word(req_word_type w);
         rsp_word_type want;
         logic [4:0]   p;
         logic [4:0]   nxt;
         logic [8:0]   cnt;
         bit           is_cmd;
         bit           fin;
         bit           rej;
         bit           ack;
         bit           tmo;
         is_cmd = (w.func >= FUNC_START) && (w.func <= FUNC_WACK);
         fin = 1'b0;
         rej = 1'b0;
         ack = 1'b0;
         tmo = 1'b0;
         if (cmd != CMD_IDLE) begin
            rej = is_cmd;
         end else if (is_cmd) begin
            cmd      = cmd_for(w.func);
            phase    = '0;
            polls    = '0;
            stop_tmo = 1'b0;
            if (w.func == FUNC_WRITE)
               shift = w.data_byte;
            else if (w.func == FUNC_SACK)
               shift = {7'd0, w.ack_level};
            else
               shift = '0;
         end

         p   = phase;
         nxt = p + 5'd1;
         case (cmd)
            CMD_START: begin
               if (p == 5'd0) {scl, sda} = 2'b11;
               else if (p == 5'd1) {scl, sda} = 2'b10;
               else begin
                  {scl, sda} = 2'b00;
                  fin = 1'b1;
               end
            end
            CMD_STOP: begin
               if (p == 5'd0) {scl, sda} = 2'b00;
               else if (p == 5'd1) {scl, sda} = 2'b10;
               else begin
                  {scl, sda} = 2'b11;
                  fin = 1'b1;
                  tmo = stop_tmo;
               end
            end
            CMD_WRITE: begin
               if (p < 5'd16) begin
                  scl = p[0];
                  sda = shift[7];
                  if (p[0]) shift = {shift[6:0], 1'b0};
               end else begin
                  scl = 1'b0;
                  fin = 1'b1;
               end
            end
            CMD_READ: begin
               if (!p[0]) begin
                  {scl, sda} = 2'b11;
                  shift = {shift[6:0], w.sda_in};
               end else begin
                  {scl, sda} = 2'b01;
                  if (p >= 5'd15) begin
                     rx_byte = shift;
                     fin = 1'b1;
                  end
               end
            end
            CMD_SACK: begin
               if (p == 5'd0) {scl, sda} = {1'b0, shift[0]};
               else if (p == 5'd1) {scl, sda} = {1'b1, shift[0]};
               else begin
                  {scl, sda} = 2'b01;
                  fin = 1'b1;
               end
            end
            CMD_WACK: begin
               if (p == 5'd0) {scl, sda} = 2'b01;
               else if (p == 5'd1) {scl, sda} = 2'b11;
               else if (p == 5'd2) begin
                  {scl, sda} = 2'b11;
                  if (!w.sda_in) begin
                     nxt = 5'd3;
                  end else begin
                     cnt = {1'b0, polls} + 9'd1;
                     if (cnt > {1'b0, poll_limit}) begin
                        cmd      = CMD_STOP;
                        stop_tmo = 1'b1;
                        nxt      = 5'd0;
                     end else begin
                        polls = cnt[7:0];
                        nxt   = 5'd2;
                     end
                  end
               end else begin
                  {scl, sda} = 2'b01;
                  ack = 1'b1;
                  fin = 1'b1;
               end
            end
            default: cmd = CMD_IDLE;
         endcase

         if (fin) begin
            cmd      = CMD_IDLE;
            phase    = '0;
            stop_tmo = 1'b0;
         end else if (cmd != CMD_IDLE) begin
            phase = nxt;
         end else begin
            phase = '0;
         end

         want.scl_out   = scl;
         want.sda_out   = sda;
         want.busy_res  = (cmd != CMD_IDLE);
         want.done_res  = fin;
         want.rx_data   = rx_byte;
         want.ack_seen  = ack;
         want.timed_out = tmo;
         want.rejected  = rej;
         expected_rsp_q.push_back(want);
      endfunction

      function string fmt_word(rsp_word_type r);
         return $sformatf("scl %b sda %b busy %b done %b rx %h ack %b tmo %b rej %b",
                          r.scl_out, r.sda_out, r.busy_res, r.done_res, r.rx_data,
                          r.ack_seen, r.timed_out, r.rejected);
      endfunction

      task report(string msg);
         errors++;
         $display("[%0t] ERROR: %s", $time, msg);
      endtask

      task check_word(rsp_word_type got);
         rsp_word_type want;
         string        diffs;
         checked++;
         if (expected_rsp_q.size() == 0) begin
            report($sformatf("rsp word %0d arrived with nothing expected: %s",
                             checked, fmt_word(got)));
            return;
         end
         want  = expected_rsp_q.pop_front();
         diffs = "";
         if (got.scl_out !== want.scl_out)     diffs = {diffs, " scl_out"};
         if (got.sda_out !== want.sda_out)     diffs = {diffs, " sda_out"};
         if (got.busy_res !== want.busy_res)   diffs = {diffs, " busy_res"};
         if (got.done_res !== want.done_res)   diffs = {diffs, " done_res"};
         if (got.rx_data !== want.rx_data)     diffs = {diffs, " rx_data"};
         if (got.ack_seen !== want.ack_seen)   diffs = {diffs, " ack_seen"};
         if (got.timed_out !== want.timed_out) diffs = {diffs, " timed_out"};
         if (got.rejected !== want.rejected)   diffs = {diffs, " rejected"};
         if (diffs != "")
            report($sformatf("rsp word %0d differs on%s: got %s, want %s",
                             checked, diffs, fmt_word(got), fmt_word(want)));
      endtask
   endclass

endpackage

>>> dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives tick words carrying commands and sampled SDA, runs bus transfers
// with random content and random stalls on both channels, and checks every
// response word against a tick-by-tick model of the engine.
// ---------------------------------------------------------------------------
module tb;
   import i2cm_pkg::*;
   import i2cm_sb_pkg::*;

   localparam logic [2:0] FUNC_SPARE = 3'd7;   // unused code, acts as a plain tick
   localparam int         RAND_WORDS = 1000;
   localparam int         PHASE_WORDS = 150;
   localparam int         NOISE_PCT = 5;

   logic clock;
   logic reset;

   i2cm_req_if req_ch();
   i2cm_rsp_if rsp_ch();
   i2cm_csr_if csr_ch();

   i2c_master_bit_engine DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   line_scoreboard sb;
   bit             burst_mode;
   bit             hold_off_req;
   int             words_sent;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #15_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Gap length: mostly none, some short, a few long; none in burst stretches.
   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic sda_level_for(int high_run, bit low_after);
      if (high_run > 0) return 1'b1;
      if (low_after) return 1'b0;
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [7:0] limit_for_phase(int idx);
      case (idx % 7)
         0: return 8'd1;
         1: return 8'd3;
         2: return 8'd254;
         3: return 8'd2;
         5: return 8'd0;
         6: return 8'd255;
         default: return 8'($urandom_range(1, 254));
      endcase
   endfunction

   // Offer one word, hold it until accepted, then feed it to the model.
   task automatic send_word(input logic [2:0] f, input logic [7:0] d,
                            input logic a, input logic s);
      req_word_type w;
      int           gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      w.func      = f;
      w.data_byte = d;
      w.ack_level = a;
      w.sda_in    = s;
      req_ch.valid     <= 1'b1;
      req_ch.func      <= f;
      req_ch.data_byte <= d;
      req_ch.ack_level <= a;
      req_ch.sda_in    <= s;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      sb.note_word(w);
      words_sent++;
   endtask

   // Issue a command from idle, then tick until the engine goes idle again.
   // SDA reads high for the first high_run ticks, then low or random.
   // While busy, a share of the ticks carry stray commands that must bounce.
   task automatic run_cmd(input logic [2:0] f, input logic [7:0] d, input logic a,
                          input int high_run, input bit low_after, input int noise_pct);
      logic [2:0] nf;
      logic [7:0] nd;
      logic       na;
      int         run;
      nf  = f;
      nd  = d;
      na  = a;
      run = high_run;
      do begin
         send_word(nf, nd, na, sda_level_for(run, low_after));
         if (run > 0) run--;
         nf = FUNC_TICK;
         if ($urandom_range(1, 100) <= noise_pct)
            nf = 3'($urandom_range(FUNC_START, FUNC_SPARE));
         nd = 8'($urandom);
         na = 1'($urandom);
      end while (sb.engine_busy());
   endtask

   // Ack wait: usually a quick ack, now and then a dead bus that must time out.
   task automatic run_ack_wait();
      int high_run;
      high_run = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(0, 4);
      run_cmd(FUNC_WACK, 8'($urandom), 1'($urandom), high_run,
              1'($urandom_range(0, 1)), NOISE_PCT);
   endtask

   // One bus transfer: start, address byte, data bytes in one direction, stop.
   task automatic run_transfer();
      int nbytes;
      bit is_read;
      nbytes  = $urandom_range(0, 3);
      is_read = $urandom_range(0, 1);
      run_cmd(FUNC_START, 8'($urandom), 1'($urandom), 0, 1'b0, NOISE_PCT);
      run_cmd(FUNC_WRITE, 8'($urandom), 1'($urandom), 0, 1'b0, NOISE_PCT);
      run_ack_wait();
      repeat (nbytes) begin
         if (is_read) begin
            run_cmd(FUNC_READ, 8'($urandom), 1'($urandom), 0, 1'b0, NOISE_PCT);
            run_cmd(FUNC_SACK, 8'($urandom), 1'($urandom), 0, 1'b0, NOISE_PCT);
         end else begin
            run_cmd(FUNC_WRITE, 8'($urandom), 1'($urandom), 0, 1'b0, NOISE_PCT);
            run_ack_wait();
         end
      end
      run_cmd(FUNC_STOP, 8'($urandom), 1'($urandom), 0, 1'b0, NOISE_PCT);
   endtask

   // Change the poll limit only with the pipe empty and the engine idle.
   task automatic write_poll_limit(input logic [7:0] v);
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.wdata <= v;
      @(posedge clock);
      while (csr_ch.ready !== 1'b1) @(posedge clock);
      csr_ch.valid <= 1'b0;
      sb.poll_limit = v;
   endtask

   // Response side: random ready stretches, plus one long hold-off on request
   // so the engine backs up and drops req ready.
   initial begin
      int n;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (80) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
            n = pick_gap();
            if (n > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
      end
   end

   // Check each response word as it moves.
   always @(posedge clock) begin
      rsp_word_type got;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.scl_out   = rsp_ch.scl_out;
         got.sda_out   = rsp_ch.sda_out;
         got.busy_res  = rsp_ch.busy_res;
         got.done_res  = rsp_ch.done_res;
         got.rx_data   = rsp_ch.rx_data;
         got.ack_seen  = rsp_ch.ack_seen;
         got.timed_out = rsp_ch.timed_out;
         got.rejected  = rsp_ch.rejected;
         sb.check_word(got);
      end
   end

   initial begin
      int directed_words;
      int phase_start;
      int phase_idx;
      sb           = new();
      burst_mode   = 1'b0;
      hold_off_req = 1'b0;
      words_sent   = 0;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.func      <= FUNC_TICK;
      req_ch.data_byte <= 8'd0;
      req_ch.ack_level <= 1'b0;
      req_ch.sda_in    <= 1'b1;
      csr_ch.valid     <= 1'b0;
      csr_ch.wdata     <= 8'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle ticks, every command, stray commands while busy,
      // full-ones and full-zeros bytes, ack and nack, timeouts at both ends
      // of the poll limit and at its reset value.
      run_cmd(FUNC_TICK, 8'h00, 1'b0, 0, 1'b0, 0);
      run_cmd(FUNC_SPARE, 8'hFF, 1'b1, 0, 1'b0, 0);
      run_cmd(FUNC_START, 8'h00, 1'b0, 0, 1'b0, 0);
      run_cmd(FUNC_WRITE, 8'hFF, 1'b1, 0, 1'b0, 0);
      run_cmd(FUNC_WACK, 8'h00, 1'b0, 0, 1'b1, 0);
      run_cmd(FUNC_WRITE, 8'h00, 1'b0, 0, 1'b0, 30);
      run_cmd(FUNC_WACK, 8'h00, 1'b0, 3, 1'b1, 0);
      run_cmd(FUNC_READ, 8'h00, 1'b0, 99, 1'b0, 0);
      run_cmd(FUNC_SACK, 8'h00, 1'b0, 0, 1'b0, 0);
      run_cmd(FUNC_READ, 8'hFF, 1'b1, 0, 1'b1, 30);
      run_cmd(FUNC_SACK, 8'hFF, 1'b1, 0, 1'b0, 0);
      run_cmd(FUNC_WACK, 8'h00, 1'b0, 1000, 1'b0, 0);   // times out at the reset limit
      run_cmd(FUNC_STOP, 8'h00, 1'b0, 0, 1'b0, 0);

      write_poll_limit(8'd0);                            // first high poll times out
      run_cmd(FUNC_WACK, 8'h00, 1'b0, 1000, 1'b0, 0);
      write_poll_limit(8'd1);                            // one high poll allowed, two not
      run_cmd(FUNC_WACK, 8'h00, 1'b0, 3, 1'b1, 0);
      run_cmd(FUNC_WACK, 8'h00, 1'b0, 4, 1'b1, 0);
      write_poll_limit(8'd255);                          // 255 high polls allowed, 256 not
      run_cmd(FUNC_WACK, 8'h00, 1'b0, 1000, 1'b0, 0);
      directed_words = words_sent;

      // Random: phases of transfers under different poll limits, with
      // some stray command runs mixed in.
      phase_idx = 0;
      while (words_sent - directed_words < RAND_WORDS) begin
         write_poll_limit(limit_for_phase(phase_idx));
         burst_mode = (phase_idx == 1) || ($urandom_range(0, 3) == 0);
         if (phase_idx == 1) hold_off_req = 1'b1;
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            if ($urandom_range(0, 5) == 0)
               run_cmd(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                       $urandom_range(0, 6), 1'b0, 20);
            else
               run_transfer();
         end
         phase_idx++;
      end

      // Drain, then give the pipe time to show any stray extra words.
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/i2cm_pkg.sv
hdl/i2cm_if.sv
hdl/i2cm_step.sv
hdl/i2c_master_bit_engine.sv
hdl/i2cm_checker.sv
dv/i2cm_sb_pkg.sv
dv/tb.sv
